FILE: rtl/signed_varint_decoder_top_defines.svh
// Assertion macros for the signed varint decoder checker.
// No dependencies; included by files that carry assertions.
`ifndef SIGNED_VARINT_DECODER_TOP_DEFINES_SVH
`define SIGNED_VARINT_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define SVD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define SVD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/svd_pkg.sv
// Shared types and codes for the signed varint decoder.
// No dependencies.
package svd_pkg;

    localparam int VALUE_W = 64;
    localparam int COUNT_W = 4;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_TRUNC = 2'd1,
        STATUS_LONG  = 2'd2
    } status_t;

    // one buffered request from the input register
    typedef struct packed {
        logic       vld;
        logic [7:0] data;
        logic       last;
    } svd_item_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] bytes_used;
        status_t            status;
    } svd_result_t;

endpackage

FILE: rtl/signed_varint_decoder_top.sv
// Top level of the signed varint decoder: input register, decode core, result register.
// Depends on svd_pkg, svd_in_stage and svd_core.
//
// Decodes one byte per cycle into signed 64-bit values stored most significant
// group first (first byte: continue, sign, 6 bits; later bytes: continue, 7 bits).
// A byte is taken every cycle as long as the result side keeps up; each byte
// sits in the input register while the shift/OR/negate logic works on it, and
// the result register loads when it is free or being drained, so a result is
// offered from the result register after its final byte leaves the input register.
// Errors (too long, truncated at buffer end) report value 0 and restart decoding.
module signed_varint_decoder_top
    import svd_pkg::*;
#(
    parameter int MAX_BYTES = 10
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_byte,
    input  logic                buffer_end,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [63:0]  value,
    output logic [3:0]          bytes_used,
    output logic [1:0]          status
);

    svd_item_t   item;
    svd_result_t res;
    logic        res_valid;
    logic        advance;

    logic        ovld_reg;
    logic        ovld_next;
    svd_result_t ores_reg;

    // stage moves when the result register is free or being drained
    assign advance = item.vld && (!ovld_reg || out_ready);

    svd_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .buffer_end (buffer_end),
        .advance    (advance),
        .item       (item)
    );

    svd_core #(
        .MAX_BYTES (MAX_BYTES)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .advance   (advance),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb
    begin
        ovld_next = ovld_reg && !out_ready;
        if (advance && res_valid)
        begin
            ovld_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovld_reg <= 1'b0;
        end
        else
        begin
            ovld_reg <= ovld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            ores_reg <= res;
        end
    end

    assign out_valid  = ovld_reg;
    assign value      = ores_reg.value;
    assign bytes_used = ores_reg.bytes_used;
    assign status     = ores_reg.status;

endmodule

FILE: rtl/svd_in_stage.sv
// Input register for the signed varint decoder.
// Depends on svd_pkg.
module svd_in_stage
    import svd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       buffer_end,
    input  logic       advance,
    output svd_item_t  item
);

    logic       vld_reg;
    logic       vld_next;
    logic [7:0] data_reg;
    logic       last_reg;

    assign in_ready = !vld_reg || advance;

    always_comb
    begin
        vld_next = vld_reg;
        if (in_ready)
        begin
            vld_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= in_byte;
            last_reg <= buffer_end;
        end
    end

    assign item.vld  = vld_reg;
    assign item.data = data_reg;
    assign item.last = last_reg;

endmodule

FILE: rtl/svd_core.sv
// Decode state and per-byte accumulate/result logic.
// Depends on svd_pkg.
module svd_core
    import svd_pkg::*;
#(
    parameter int MAX_BYTES = 10
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  svd_item_t   item,
    input  logic        advance,
    output logic        res_valid,
    output svd_result_t res
);

    localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_BYTES);

    logic [VALUE_W-1:0] acc_reg;
    logic [VALUE_W-1:0] acc_next;
    logic [COUNT_W-1:0] cnt_reg;
    logic [COUNT_W-1:0] cnt_next;
    logic               sign_reg;
    logic               sign_next;

    logic [VALUE_W-1:0] acc_upd;
    logic               sign_upd;
    logic [COUNT_W-1:0] count;
    logic               more;

    always_comb
    begin
        // first byte: sign in bit 6, six magnitude bits
        if (cnt_reg == '0)
        begin
            acc_upd  = {{(VALUE_W-6){1'b0}}, item.data[5:0]};
            sign_upd = item.data[6];
        end
        else
        begin
            acc_upd  = {acc_reg[VALUE_W-8:0], item.data[6:0]};
            sign_upd = sign_reg;
        end
        count = cnt_reg + COUNT_W'(1);
        more  = item.data[7];
    end

    always_comb
    begin
        res_valid      = 1'b1;
        res.value      = '0;
        res.bytes_used = count;
        res.status     = STATUS_OK;
        acc_next       = '0;
        cnt_next       = '0;
        sign_next      = 1'b0;
        if (!more)
        begin
            res.value = sign_upd ? (VALUE_W'(0) - acc_upd) : acc_upd;
        end
        else if (count >= MAX_CNT)
        begin
            res.status = STATUS_LONG;
        end
        else if (item.last)
        begin
            res.status = STATUS_TRUNC;
        end
        else
        begin
            res_valid = 1'b0;
            acc_next  = acc_upd;
            cnt_next  = count;
            sign_next = sign_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            cnt_reg  <= '0;
            sign_reg <= 1'b0;
        end
        else if (advance)
        begin
            acc_reg  <= acc_next;
            cnt_reg  <= cnt_next;
            sign_reg <= sign_next;
        end
    end

endmodule

FILE: rtl/svd_checker.sv
// Port-level checks for the signed varint decoder, bound to the top level.
// Depends on svd_pkg and signed_varint_decoder_top_defines.svh.
`include "signed_varint_decoder_top_defines.svh"

module svd_checker
    import svd_pkg::*;
#(
    parameter int MAX_BYTES = 10
)
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] value,
    input logic [3:0]  bytes_used,
    input logic [1:0]  status
);

    localparam logic [3:0] MAX_CNT = 4'(MAX_BYTES);

    logic        stalled;
    logic        err_out;
    logic        count_ok;
    logic [69:0] res_bus;

    assign stalled  = out_valid && !out_ready;
    assign err_out  = out_valid && (status == STATUS_TRUNC || status == STATUS_LONG);
    assign res_bus  = {value, bytes_used, status};
    // too long always reports the full byte budget; others stay within it
    assign count_ok = (status == STATUS_LONG) ? (bytes_used == MAX_CNT)
                                              : (bytes_used != 4'd0 && bytes_used <= MAX_CNT);

    // a stalled result must hold
    `SVD_ASSERT_NXT(a_hold, clk, rst_n, stalled, out_valid && $stable(res_bus), "result not held")

    // errors carry a zero value
    `SVD_ASSERT_IMP(a_err_zero, clk, rst_n, err_out, value == 64'd0, "error value not zero")

    `SVD_ASSERT_IMP(a_count, clk, rst_n, out_valid, count_ok, "bytes_used out of range")

    // a draining consumer never stalls the producer
    `SVD_ASSERT_IMP(a_no_stall, clk, rst_n, out_ready, in_ready, "input stalled while draining")

endmodule

bind signed_varint_decoder_top svd_checker #(
    .MAX_BYTES (MAX_BYTES)
) u_svd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .value      (value),
    .bytes_used (bytes_used),
    .status     (status)
);
